/* sv/dcp_pkg.sv */
`timescale 1ns / 1ps

package dcp_pkg;

   // Default coordinate format.
   localparam int COORD_BITS_DEFAULT = 24;
   localparam int FRAC_BITS_DEFAULT  = 8;

   // The distance limit register is always 24 bits wide.
   localparam int LIMIT_BITS = 24;

   // Distance limit after reset, in whole units (scaled by the fraction bits).
   localparam int LIMIT_RESET_UNITS = 100;

endpackage

/* sv/dcp_req_if.sv */
`timescale 1ns / 1ps

interface dcp_req_if #(
   parameter int COORD_BITS = dcp_pkg::COORD_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] anchor_x;
   logic signed [COORD_BITS-1:0] anchor_y;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;

   modport source (output valid, anchor_x, anchor_y, target_x, target_y, input ready);
   modport sink   (input valid, anchor_x, anchor_y, target_x, target_y, output ready);
endinterface

/* sv/dcp_rsp_if.sv */
`timescale 1ns / 1ps

interface dcp_rsp_if #(
   parameter int COORD_BITS = dcp_pkg::COORD_BITS_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] new_x;
   logic signed [COORD_BITS-1:0] new_y;
   logic                         was_clamped;

   modport source (output valid, new_x, new_y, was_clamped, input ready);
   modport sink   (input valid, new_x, new_y, was_clamped, output ready);
endinterface

/* sv/dcp_sqrt_cell.sv */
`timescale 1ns / 1ps

// One bit of the square root: tries setting bit STEP of the root against
// the remainder (radicand minus root squared so far).
module dcp_sqrt_cell #(
   parameter int SW     = 49,
   parameter int RW     = 25,
   parameter int STEP   = 0,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SW-1:0]     in_rem,
   input  logic [RW-1:0]     in_root,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [SW-1:0]     out_rem,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);
   localparam int CW = 2 * RW + 2;

   logic              valid_ff;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;
   logic [CW-1:0]     trial;
   logic [CW-1:0]     rem_wide;
   logic              fits;

   always_comb begin
      trial    = (CW'(in_root) << (STEP + 1)) | (CW'(1) << (2 * STEP));
      rem_wide = CW'(in_rem);
      fits     = rem_wide >= trial;
      rem_in   = fits ? SW'(rem_wide - trial) : in_rem;
      root_in  = fits ? (in_root | (RW'(1) << STEP)) : in_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;
endmodule

/* sv/dcp_div_cell.sv */
`timescale 1ns / 1ps

// One quotient bit for both axes: subtracts the length shifted by STEP
// from each partial remainder where it fits.
module dcp_div_cell #(
   parameter int NW     = 48,
   parameter int LW     = 25,
   parameter int QW     = 24,
   parameter int STEP   = 0,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [LW-1:0]     in_len,
   input  logic [NW-1:0]     in_rem_x,
   input  logic [NW-1:0]     in_rem_y,
   input  logic [QW-1:0]     in_q_x,
   input  logic [QW-1:0]     in_q_y,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [LW-1:0]     out_len,
   output logic [NW-1:0]     out_rem_x,
   output logic [NW-1:0]     out_rem_y,
   output logic [QW-1:0]     out_q_x,
   output logic [QW-1:0]     out_q_y,
   output logic [SIDE_W-1:0] out_side
);
   localparam int CW = ((NW > LW + QW) ? NW : LW + QW) + 1;

   logic              valid_ff;
   logic [LW-1:0]     len_ff;
   logic [NW-1:0]     rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [QW-1:0]     q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic [SIDE_W-1:0] side_ff;
   logic [CW-1:0]     trial;
   logic              fit_x, fit_y;

   always_comb begin
      trial    = CW'(in_len) << STEP;
      fit_x    = CW'(in_rem_x) >= trial;
      fit_y    = CW'(in_rem_y) >= trial;
      rem_x_in = fit_x ? NW'(CW'(in_rem_x) - trial) : in_rem_x;
      rem_y_in = fit_y ? NW'(CW'(in_rem_y) - trial) : in_rem_y;
      q_x_in   = fit_x ? (in_q_x | (QW'(1) << STEP)) : in_q_x;
      q_y_in   = fit_y ? (in_q_y | (QW'(1) << STEP)) : in_q_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         len_ff   <= in_len;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_len   = len_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_side  = side_ff;
endmodule

/* sv/distance_constraint_projector_core.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Carries
// req_if    | in        | anchor_x, anchor_y, target_x, target_y
// rsp_if    | out       | new_x, new_y, was_clamped
// csr_*     | in        | max_distance (write only)
//
// One request is taken every cycle while the result channel does not stall.
// A request passes the input and square stages, the square root cells (one
// root bit each), the product stage, the divider cells (one quotient bit
// each) and the output register. Reset is synchronous, clears every valid
// flag and returns the distance limit to 100 units.
// A stall on the result channel freezes the whole pipeline; while the
// result register is free or being taken, requests keep flowing.
module distance_constraint_projector_core #(
   parameter int COORD_BITS = dcp_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = dcp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   dcp_req_if.sink                       req_if,
   dcp_rsp_if.source                     rsp_if,
   input  logic                          csr_we,
   input  logic [dcp_pkg::LIMIT_BITS-1:0] csr_wdata
);
   localparam int LB = dcp_pkg::LIMIT_BITS;
   // The offset is COORD_BITS+1 bits signed; its magnitude fits COORD_BITS.
   localparam int DW = COORD_BITS + 1;
   localparam int MW = COORD_BITS;
   localparam int SW = 2 * MW + 1;        // sum of squares
   localparam int RW = MW + 1;            // root
   localparam int QW = MW;                // when clamped, the quotient never exceeds the magnitude
   localparam int NW = MW + LB;           // magnitude times limit
   localparam int SIDE_W = 2 * COORD_BITS + 2 * DW;
   localparam int DSIDE_W = SIDE_W + 2;
   localparam logic [LB-1:0] LIMIT_RESET =
      LB'(dcp_pkg::LIMIT_RESET_UNITS << FRAC_BITS);

   // Limit: the user writes it only while the pipeline is empty (unchecked).
   logic [LB-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // Pipeline advance: everything moves unless a finished result is held.
   logic en;
   logic rsp_valid_ff;

   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // Input stage: register the anchor and the offset.
   logic                         s0_valid_ff;
   logic signed [COORD_BITS-1:0] s0_ax_ff, s0_ay_ff;
   logic signed [DW-1:0]         s0_dx_ff, s0_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_if.valid;
      end
      if (en) begin
         s0_ax_ff <= req_if.anchor_x;
         s0_ay_ff <= req_if.anchor_y;
         s0_dx_ff <= DW'(req_if.target_x) - DW'(req_if.anchor_x);
         s0_dy_ff <= DW'(req_if.target_y) - DW'(req_if.anchor_y);
      end
   end

   // Square stage: one multiplier per axis, registered.
   logic [MW-1:0]     s0_mx, s0_my;
   logic              s1_valid_ff;
   logic [2*MW-1:0]   s1_sqx_ff, s1_sqy_ff;
   logic [SIDE_W-1:0] s1_side_ff;

   assign s0_mx = s0_dx_ff[DW-1] ? MW'(-s0_dx_ff) : MW'(s0_dx_ff);
   assign s0_my = s0_dy_ff[DW-1] ? MW'(-s0_dy_ff) : MW'(s0_dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (en) begin
         s1_sqx_ff  <= s0_mx * s0_mx;
         s1_sqy_ff  <= s0_my * s0_my;
         s1_side_ff <= {s0_ax_ff, s0_ay_ff, s0_dx_ff, s0_dy_ff};
      end
   end

   // Square root chain: one cell per root bit, most significant first.
   logic              sq_valid [0:RW];
   logic [SW-1:0]     sq_rem   [0:RW];
   logic [RW-1:0]     sq_root  [0:RW];
   logic [SIDE_W-1:0] sq_side  [0:RW];

   assign sq_valid[0] = s1_valid_ff;
   assign sq_rem[0]   = SW'(s1_sqx_ff) + SW'(s1_sqy_ff);
   assign sq_root[0]  = '0;
   assign sq_side[0]  = s1_side_ff;

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      dcp_sqrt_cell #(
         .SW(SW), .RW(RW), .STEP(RW - 1 - i), .SIDE_W(SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (sq_valid[i]),
         .in_rem   (sq_rem[i]),
         .in_root  (sq_root[i]),
         .in_side  (sq_side[i]),
         .out_valid(sq_valid[i+1]),
         .out_rem  (sq_rem[i+1]),
         .out_root (sq_root[i+1]),
         .out_side (sq_side[i+1])
      );
   end

   // Product stage: decide the path and form magnitude times limit.
   logic signed [COORD_BITS-1:0] pq_ax, pq_ay;
   logic signed [DW-1:0]         pq_dx, pq_dy;
   logic [MW-1:0]                pq_mx, pq_my;
   logic                         p_valid_ff;
   logic [RW-1:0]                p_len_ff;
   logic [NW-1:0]                p_prod_x_ff, p_prod_y_ff;
   logic [DSIDE_W-1:0]           p_side_ff;
   logic                         pq_pass, pq_zero;

   always_comb begin
      {pq_ax, pq_ay, pq_dx, pq_dy} = sq_side[RW];
      pq_mx   = pq_dx[DW-1] ? MW'(-pq_dx) : MW'(pq_dx);
      pq_my   = pq_dy[DW-1] ? MW'(-pq_dy) : MW'(pq_dy);
      // The target passes when the length is below the limit.
      pq_pass = (RW + LB)'(sq_root[RW]) < (RW + LB)'(limit_ff);
      pq_zero = sq_root[RW] == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= sq_valid[RW];
      end
      if (en) begin
         p_len_ff    <= sq_root[RW];
         p_prod_x_ff <= NW'(pq_mx * limit_ff);
         p_prod_y_ff <= NW'(pq_my * limit_ff);
         p_side_ff   <= {sq_side[RW], pq_pass, pq_zero};
      end
   end

   // Divider chain: one cell per quotient bit, both axes side by side.
   logic               dv_valid [0:QW];
   logic [RW-1:0]      dv_len   [0:QW];
   logic [NW-1:0]      dv_rem_x [0:QW];
   logic [NW-1:0]      dv_rem_y [0:QW];
   logic [QW-1:0]      dv_q_x   [0:QW];
   logic [QW-1:0]      dv_q_y   [0:QW];
   logic [DSIDE_W-1:0] dv_side  [0:QW];

   assign dv_valid[0] = p_valid_ff;
   assign dv_len[0]   = p_len_ff;
   assign dv_rem_x[0] = p_prod_x_ff;
   assign dv_rem_y[0] = p_prod_y_ff;
   assign dv_q_x[0]   = '0;
   assign dv_q_y[0]   = '0;
   assign dv_side[0]  = p_side_ff;

   for (genvar i = 0; i < QW; i++) begin : g_div
      dcp_div_cell #(
         .NW(NW), .LW(RW), .QW(QW), .STEP(QW - 1 - i), .SIDE_W(DSIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (dv_valid[i]),
         .in_len   (dv_len[i]),
         .in_rem_x (dv_rem_x[i]),
         .in_rem_y (dv_rem_y[i]),
         .in_q_x   (dv_q_x[i]),
         .in_q_y   (dv_q_y[i]),
         .in_side  (dv_side[i]),
         .out_valid(dv_valid[i+1]),
         .out_len  (dv_len[i+1]),
         .out_rem_x(dv_rem_x[i+1]),
         .out_rem_y(dv_rem_y[i+1]),
         .out_q_x  (dv_q_x[i+1]),
         .out_q_y  (dv_q_y[i+1]),
         .out_side (dv_side[i+1])
      );
   end

   // Output stage: restore the signs, add the anchor, saturate and select.
   localparam int EW = COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] o_ax, o_ay;
   logic signed [DW-1:0]         o_dx, o_dy;
   logic                         o_pass, o_zero;
   logic signed [EW-1:0]         o_sum_x, o_sum_y;
   logic signed [COORD_BITS-1:0] o_sat_x, o_sat_y, o_x, o_y;
   logic signed [COORD_BITS-1:0] new_x_ff, new_y_ff;
   logic                         clamped_ff;

   function automatic logic [COORD_BITS-1:0] saturate(input logic [EW-1:0] v);
      logic [COORD_BITS-1:0] r;
      // The value fits when its three top bits agree.
      if (v[EW-1:COORD_BITS-1] == '0 || v[EW-1:COORD_BITS-1] == '1) begin
         r = v[COORD_BITS-1:0];
      end else if (v[EW-1]) begin
         r = {1'b1, {(COORD_BITS - 1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_BITS - 1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      {o_ax, o_ay, o_dx, o_dy, o_pass, o_zero} = dv_side[QW];
      o_sum_x = EW'(o_ax) + (o_dx[DW-1] ? -EW'(dv_q_x[QW]) : EW'(dv_q_x[QW]));
      o_sum_y = EW'(o_ay) + (o_dy[DW-1] ? -EW'(dv_q_y[QW]) : EW'(dv_q_y[QW]));
      o_sat_x = saturate(o_sum_x);
      o_sat_y = saturate(o_sum_y);
      priority if (o_pass) begin
         // The target is anchor plus offset and always fits.
         o_x = COORD_BITS'(DW'(o_ax) + o_dx);
         o_y = COORD_BITS'(DW'(o_ay) + o_dy);
      end else if (o_zero) begin
         // Zero length with a zero limit collapses onto the anchor.
         o_x = o_ax;
         o_y = o_ay;
      end else begin
         o_x = o_sat_x;
         o_y = o_sat_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[QW];
      end
      if (en) begin
         new_x_ff   <= o_x;
         new_y_ff   <= o_y;
         clamped_ff <= !o_pass;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.new_x       = new_x_ff;
   assign rsp_if.new_y       = new_y_ff;
   assign rsp_if.was_clamped = clamped_ff;
endmodule
